[sv/lnf_pkg.sv]
// ============================================================================
// lnf_pkg
// Shared types and constants for the layer normalization forward block.
// ============================================================================
`default_nettype none

package lnf_pkg;

    localparam int DATA_WIDTH       = 16;
    localparam int FRAC_BITS        = 12;
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int CFG_COUNT_W      = 11;
    localparam int CFG_EPS_W        = 24;
    localparam int INV_W            = 32;
    localparam int OPW              = 64;
    localparam int ITER_DIV_STEPS   = 64;
    localparam int ITER_SQRT_STEPS  = 32;
    localparam int PADDR_W          = 4;
    localparam int PDATA_W          = 32;

    localparam logic [CFG_COUNT_W-1:0] COUNT_RESET = CFG_COUNT_W'(1024);
    localparam logic [CFG_EPS_W-1:0]   EPS_RESET   = CFG_EPS_W'(168);
    localparam logic [OPW-1:0]         ONE_Q24     = OPW'(1) << 24;
    localparam logic [OPW-1:0]         ONE_Q56     = OPW'(1) << 56;
    localparam logic [INV_W-1:0]       INV_MAX     = '1;

    typedef enum logic [1:0] {
        REG_ELEMENT_COUNT = 2'd0,
        REG_EPSILON       = 2'd1,
        REG_USE_SCALE     = 2'd2,
        REG_USE_BIAS      = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_APPLY = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        PH_LOADING  = 2'd0,
        PH_APPLYING = 2'd1
    } phase_t;

    typedef enum logic {
        ITER_DIV  = 1'b0,
        ITER_SQRT = 1'b1
    } iter_mode_t;

    typedef struct packed {
        logic       start;
        iter_mode_t mode;
    } iter_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MEAN,
        ST_MEAN_W,
        ST_VMUL,
        ST_VSTART,
        ST_VDIV_W,
        ST_TOTAL,
        ST_RDIV_W,
        ST_SQRT_W,
        ST_AP_RD,
        ST_AP_DIFF,
        ST_AP_MUL,
        ST_AP_SCALE,
        ST_AP_OUT
    } state_t;

endpackage

`default_nettype wire

[sv/lnf_store.sv]
// ============================================================================
// lnf_store
// Sample element memory: one write port, one registered read port.
// ============================================================================
`default_nettype none

module lnf_store #(
    parameter int DEPTH = lnf_pkg::MAX_ELEMENTS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [ADDR_W-1:0]                     wr_addr,
    input  wire logic signed [lnf_pkg::DATA_WIDTH-1:0] wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [ADDR_W-1:0]                     rd_addr,
    output logic signed [lnf_pkg::DATA_WIDTH-1:0]      rd_data
);
    import lnf_pkg::*;

    logic signed [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/lnf_iter.sv]
// ============================================================================
// lnf_iter
// Shared compare-subtract unit: restoring divide (64 steps) or integer
// square root (32 steps), one step per cycle.
// ============================================================================
`default_nettype none

module lnf_iter (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lnf_pkg::iter_req_t          req,
    input  wire logic [lnf_pkg::OPW-1:0]     op_a,
    input  wire logic [lnf_pkg::OPW-1:0]     op_b,
    output logic                             done,
    output logic [lnf_pkg::OPW-1:0]          result
);
    import lnf_pkg::*;

    localparam int CNT_IW = $clog2(ITER_DIV_STEPS + 1);

    logic [OPW:0]        acc_reg;
    logic [OPW-1:0]      quo_reg;
    logic [OPW-1:0]      src_reg;
    logic [OPW-1:0]      dvs_reg;
    logic [CNT_IW-1:0]   cnt_reg;
    iter_mode_t          mode_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [OPW:0]        rem_sh;
    logic [OPW+1:0]      opa;
    logic [OPW+1:0]      opb;
    logic [OPW+1:0]      sub;
    logic                ge;

    always_comb
    begin
        rem_sh = {acc_reg[OPW-1:0], src_reg[OPW-1]};
        if (mode_reg == ITER_DIV)
        begin
            opa = {1'b0, rem_sh};
            opb = {2'b00, dvs_reg};
        end
        else
        begin
            opa = {2'b00, acc_reg[OPW-1:0]};
            opb = {2'b00, quo_reg | src_reg};
        end
        sub = opa - opb;
        ge  = ~sub[OPW+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= ITER_DIV;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            mode_reg <= req.mode;
            cnt_reg  <= (req.mode == ITER_DIV) ? CNT_IW'(ITER_DIV_STEPS)
                                               : CNT_IW'(ITER_SQRT_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_IW'(1);
            if (cnt_reg == CNT_IW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= '0;
            dvs_reg <= op_b;
            if (req.mode == ITER_DIV)
            begin
                acc_reg <= '0;
                src_reg <= op_a;
            end
            else
            begin
                acc_reg <= {1'b0, op_a};
                src_reg <= OPW'(1) << (OPW - 2);
            end
        end
        else if (busy_reg)
        begin
            if (mode_reg == ITER_DIV)
            begin
                acc_reg <= ge ? sub[OPW:0] : rem_sh;
                quo_reg <= {quo_reg[OPW-2:0], ge};
                src_reg <= src_reg << 1;
            end
            else
            begin
                if (ge)
                begin
                    acc_reg <= {1'b0, sub[OPW-1:0]};
                    quo_reg <= (quo_reg >> 1) | src_reg;
                end
                else
                begin
                    quo_reg <= quo_reg >> 1;
                end
                src_reg <= src_reg >> 2;
            end
        end
    end

    assign done   = done_reg;
    assign result = quo_reg;

endmodule

`default_nettype wire

[sv/layer_norm_forward.sv]
// ============================================================================
// layer_norm_forward
// Layer normalization of one sample vector: load, statistics, apply.
// ============================================================================
//  channel  | direction | tdata                              | tuser      | tlast
//  s_axis   | in        | element, scale, bias (16b each)    | kind       | -
//  m_axis   | out       | normalized_value (16b)             | saturated  | is_last
//  apb      | in/out    | element_count, epsilon, use_scale, use_bias
//
//  A load item writes the element store; an apply item passes through the
//  store read, the difference and the two multiply stages to the result.
//  The last load adds the statistics pass on the shared divide/sqrt unit:
//  mean divide, variance divide, reciprocal divide at 64 steps each, then
//  square root at 32 steps.
//  Reset is asynchronous; the element store has no clearing pass.
//  The result register holds while it is valid and m_tready is low; an apply
//  waiting to write it stalls, and no input item is taken until it does.
// ============================================================================
`default_nettype none

module layer_norm_forward #(
    parameter int MAX_ELEMENTS = lnf_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [15:0] element_value, [31:16] scale_value, [47:32] bias_value
    input  wire logic [3*lnf_pkg::DATA_WIDTH-1:0]    s_tdata,
    // [0] kind
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [15:0] normalized_value
    output logic [lnf_pkg::DATA_WIDTH-1:0]           m_tdata,
    output logic                                     m_tlast,
    // [0] saturated
    output logic                                     m_tuser,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lnf_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [lnf_pkg::PDATA_W-1:0]         pwdata,
    output logic [lnf_pkg::PDATA_W-1:0]              prdata,
    output logic                                     pready
);
    import lnf_pkg::*;

    localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
    localparam int ADDR_W  = $clog2(MAX_ELEMENTS);
    localparam int SUM_W   = DATA_WIDTH + CNT_W;
    localparam int SQ_W    = 2 * DATA_WIDTH - 1 + CNT_W;
    localparam int MEAN_W  = SUM_W + 1;
    localparam int XS_W    = DATA_WIDTH + FRAC_BITS;
    localparam int D_W     = ((XS_W > MEAN_W) ? XS_W : MEAN_W) + 1;
    localparam int N24_W   = D_W + INV_W + 1 - 16;
    localparam int M12_W   = N24_W + DATA_WIDTH + 1 - 24;
    localparam int M12U_W  = N24_W + 1 - 12;
    localparam int VAL_W   = M12_W + 2;
    localparam int OUT_MAX = 2 ** (DATA_WIDTH - 1) - 1;
    localparam int OUT_MIN = -OUT_MAX - 1;

    // configuration
    logic [CFG_COUNT_W-1:0] cfg_count_reg;
    logic [CFG_EPS_W-1:0]   cfg_eps_reg;
    logic                   cfg_scale_reg;
    logic                   cfg_bias_reg;
    logic                   cfg_wr;
    cfg_reg_t               cfg_sel;

    // control
    state_t                 state_reg;
    state_t                 state_next;
    phase_t                 phase_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       n_act;
    logic [CNT_W:0]         idx_inc;
    logic                   idx_last;
    logic                   accept_in;
    logic                   out_free;

    // item and statistics
    logic signed [DATA_WIDTH-1:0] x_reg;
    logic signed [DATA_WIDTH-1:0] sc_reg;
    logic signed [DATA_WIDTH-1:0] bi_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic [SQ_W-1:0]              sq_reg;
    logic signed [MEAN_W-1:0]     mean_reg;
    logic [INV_W-1:0]             inv_reg;
    logic [OPW-1:0]               nsq_reg;
    logic [OPW-1:0]               s2_reg;
    logic [OPW-1:0]               nn_reg;
    logic [OPW-1:0]               var_reg;
    logic [OPW-1:0]               total;
    logic [DATA_WIDTH-1:0]        x_mag;
    logic [2*DATA_WIDTH-1:0]      x_sq;
    logic [SUM_W-1:0]             smag;
    logic [CNT_W+SQ_W-1:0]        nsq_full;
    logic [2*SUM_W-1:0]           s2_full;
    logic [2*CNT_W-1:0]           nn_full;

    // apply path
    logic signed [DATA_WIDTH-1:0] rd_data;
    logic signed [D_W-1:0]        d_val;
    logic [D_W-1:0]               dm_reg;
    logic                         neg_reg;
    logic [N24_W-1:0]             n24_reg;
    logic [D_W+INV_W:0]           p1;
    logic [DATA_WIDTH-1:0]        sc_mag;
    logic [N24_W+DATA_WIDTH:0]    p2;
    logic [N24_W:0]               p3;
    logic [M12_W-1:0]             m12_reg;
    logic                         neg2_reg;
    logic signed [VAL_W-1:0]      mag_ext;
    logic signed [VAL_W-1:0]      val;
    logic                         sat_hi;
    logic                         sat_lo;

    logic                         out_valid_reg;
    logic [DATA_WIDTH-1:0]        out_data_reg;
    logic                         out_last_reg;
    logic                         out_sat_reg;

    // shared unit and store
    iter_req_t                    iter_req;
    logic [OPW-1:0]               iter_a;
    logic [OPW-1:0]               iter_b;
    logic                         iter_done;
    logic [OPW-1:0]               iter_result;
    logic                         mem_we;
    logic                         mem_re;

    // ------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_count_reg <= COUNT_RESET;
            cfg_eps_reg   <= EPS_RESET;
            cfg_scale_reg <= 1'b0;
            cfg_bias_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_ELEMENT_COUNT: cfg_count_reg <= pwdata[CFG_COUNT_W-1:0];
                REG_EPSILON:       cfg_eps_reg   <= pwdata[CFG_EPS_W-1:0];
                REG_USE_SCALE:     cfg_scale_reg <= pwdata[0];
                REG_USE_BIAS:      cfg_bias_reg  <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_ELEMENT_COUNT: prdata = PDATA_W'(cfg_count_reg);
            REG_EPSILON:       prdata = PDATA_W'(cfg_eps_reg);
            REG_USE_SCALE:     prdata = PDATA_W'(cfg_scale_reg);
            REG_USE_BIAS:      prdata = PDATA_W'(cfg_bias_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Common terms
    // ------------------------------------------------------------------
    always_comb
    begin
        if (cfg_count_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (32'(cfg_count_reg) > MAX_ELEMENTS)
        begin
            n_act = CNT_W'(MAX_ELEMENTS);
        end
        else
        begin
            n_act = CNT_W'(cfg_count_reg);
        end
    end

    assign idx_inc   = {1'b0, idx_reg} + (CNT_W+1)'(1);
    assign idx_last  = idx_inc >= {1'b0, n_act};
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept_in = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign x_mag    = x_reg[DATA_WIDTH-1] ? $unsigned(-x_reg) : $unsigned(x_reg);
    assign x_sq     = x_mag * x_mag;
    assign smag     = sum_reg[SUM_W-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);
    assign nsq_full = n_act * sq_reg;
    assign s2_full  = smag * smag;
    assign nn_full  = n_act * n_act;
    assign total    = var_reg + OPW'(cfg_eps_reg);

    assign d_val   = (D_W'(rd_data) <<< FRAC_BITS) - D_W'(mean_reg);
    assign p1      = dm_reg * inv_reg + (D_W+INV_W+1)'(32768);
    assign sc_mag  = sc_reg[DATA_WIDTH-1] ? $unsigned(-sc_reg) : $unsigned(sc_reg);
    assign p2      = n24_reg * sc_mag + (N24_W+DATA_WIDTH+1)'(8388608);
    assign p3      = {1'b0, n24_reg} + (N24_W+1)'(2048);

    always_comb
    begin
        mag_ext = $signed({2'b00, m12_reg});
        val     = neg2_reg ? -mag_ext : mag_ext;
        if (cfg_bias_reg)
        begin
            val = val + VAL_W'(bi_reg);
        end
        sat_hi = val > $signed(VAL_W'(OUT_MAX));
        sat_lo = val < $signed(VAL_W'(OUT_MIN));
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    if (kind_t'(s_tuser) == KIND_LOAD && phase_reg == PH_LOADING)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (kind_t'(s_tuser) == KIND_APPLY && phase_reg == PH_APPLYING)
                    begin
                        state_next = ST_AP_RD;
                    end
                end
            end
            ST_LOAD:     state_next = idx_last ? ST_MEAN : ST_IDLE;
            ST_MEAN:     state_next = ST_MEAN_W;
            ST_MEAN_W:   state_next = iter_done ? ST_VMUL : ST_MEAN_W;
            ST_VMUL:     state_next = ST_VSTART;
            ST_VSTART:
            begin
                if (n_act == CNT_W'(1) || nsq_reg <= s2_reg)
                begin
                    state_next = ST_TOTAL;
                end
                else
                begin
                    state_next = ST_VDIV_W;
                end
            end
            ST_VDIV_W:   state_next = iter_done ? ST_TOTAL : ST_VDIV_W;
            ST_TOTAL:    state_next = (total == '0) ? ST_IDLE : ST_RDIV_W;
            ST_RDIV_W:   state_next = iter_done ? ST_SQRT_W : ST_RDIV_W;
            ST_SQRT_W:   state_next = iter_done ? ST_IDLE : ST_SQRT_W;
            ST_AP_RD:    state_next = ST_AP_DIFF;
            ST_AP_DIFF:  state_next = ST_AP_MUL;
            ST_AP_MUL:   state_next = ST_AP_SCALE;
            ST_AP_SCALE: state_next = ST_AP_OUT;
            ST_AP_OUT:   state_next = out_free ? ST_IDLE : ST_AP_OUT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs to the shared unit and the store
    // ------------------------------------------------------------------
    always_comb
    begin
        iter_req.start = 1'b0;
        iter_req.mode  = ITER_DIV;
        iter_a         = '0;
        iter_b         = '0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                mem_we = 1'b1;
            end
            ST_MEAN:
            begin
                iter_req.start = 1'b1;
                iter_a         = OPW'({smag, FRAC_BITS'(0)});
                iter_b         = OPW'(n_act);
            end
            ST_VSTART:
            begin
                if (!(n_act == CNT_W'(1) || nsq_reg <= s2_reg))
                begin
                    iter_req.start = 1'b1;
                    iter_a         = nsq_reg - s2_reg;
                    iter_b         = nn_reg;
                end
            end
            ST_TOTAL:
            begin
                if (total != '0)
                begin
                    iter_req.start = 1'b1;
                    iter_a         = ONE_Q56;
                    iter_b         = total;
                end
            end
            ST_RDIV_W:
            begin
                if (iter_done)
                begin
                    iter_req.start = 1'b1;
                    iter_req.mode  = ITER_SQRT;
                    iter_a         = iter_result;
                end
            end
            ST_AP_RD:
            begin
                mem_re = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_LOADING;
            idx_reg       <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            mean_reg      <= '0;
            inv_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_LOAD:
                begin
                    sum_reg <= sum_reg + SUM_W'(x_reg);
                    sq_reg  <= sq_reg + SQ_W'(x_sq);
                    idx_reg <= idx_last ? '0 : idx_inc[CNT_W-1:0];
                end
                ST_MEAN_W:
                begin
                    if (iter_done)
                    begin
                        mean_reg <= sum_reg[SUM_W-1] ? -$signed(MEAN_W'(iter_result))
                                                     : $signed(MEAN_W'(iter_result));
                    end
                end
                ST_TOTAL:
                begin
                    if (total == '0)
                    begin
                        inv_reg   <= INV_MAX;
                        sum_reg   <= '0;
                        sq_reg    <= '0;
                        phase_reg <= PH_APPLYING;
                    end
                end
                ST_SQRT_W:
                begin
                    if (iter_done)
                    begin
                        inv_reg   <= iter_result[INV_W-1:0];
                        sum_reg   <= '0;
                        sq_reg    <= '0;
                        phase_reg <= PH_APPLYING;
                    end
                end
                ST_AP_OUT:
                begin
                    if (out_free)
                    begin
                        idx_reg <= idx_last ? '0 : idx_inc[CNT_W-1:0];
                        if (idx_last)
                        begin
                            phase_reg <= PH_LOADING;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (state_reg == ST_AP_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            x_reg  <= $signed(s_tdata[DATA_WIDTH-1:0]);
            sc_reg <= $signed(s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
            bi_reg <= $signed(s_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]);
        end
        case (state_reg)
            ST_VMUL:
            begin
                nsq_reg <= OPW'(nsq_full);
                s2_reg  <= OPW'(s2_full);
                nn_reg  <= OPW'(nn_full);
            end
            ST_VSTART:
            begin
                // count of one gives unit variance; negative variance floors at zero
                var_reg <= (n_act == CNT_W'(1)) ? ONE_Q24 : '0;
            end
            ST_VDIV_W:
            begin
                if (iter_done)
                begin
                    var_reg <= iter_result;
                end
            end
            ST_AP_DIFF:
            begin
                dm_reg  <= d_val[D_W-1] ? $unsigned(-d_val) : $unsigned(d_val);
                neg_reg <= d_val[D_W-1];
            end
            ST_AP_MUL:
            begin
                n24_reg <= p1[D_W+INV_W:16];
            end
            ST_AP_SCALE:
            begin
                if (cfg_scale_reg)
                begin
                    m12_reg  <= p2[N24_W+DATA_WIDTH:24];
                    neg2_reg <= neg_reg ^ sc_reg[DATA_WIDTH-1];
                end
                else
                begin
                    m12_reg  <= M12_W'(p3[N24_W:12]);
                    neg2_reg <= neg_reg;
                end
            end
            ST_AP_OUT:
            begin
                if (out_free)
                begin
                    out_last_reg <= idx_last;
                    out_sat_reg  <= sat_hi || sat_lo;
                    if (sat_hi)
                    begin
                        out_data_reg <= DATA_WIDTH'(OUT_MAX);
                    end
                    else if (sat_lo)
                    begin
                        out_data_reg <= DATA_WIDTH'(OUT_MIN);
                    end
                    else
                    begin
                        out_data_reg <= val[DATA_WIDTH-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_sat_reg;

    // ------------------------------------------------------------------
    // Submodules
    // ------------------------------------------------------------------
    lnf_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (iter_req),
        .op_a   (iter_a),
        .op_b   (iter_b),
        .done   (iter_done),
        .result (iter_result)
    );

    lnf_store #(
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (idx_reg[ADDR_W-1:0]),
        .wr_data (x_reg),
        .rd_en   (mem_re),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

[sv/lnf_checker.sv]
// ============================================================================
// lnf_checker
// Port-level checks on the layer normalization block.
// ============================================================================
`default_nettype none

module lnf_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [lnf_pkg::DATA_WIDTH-1:0]    m_tdata,
    input wire logic                              m_tlast,
    input wire logic                              m_tuser
);
    import lnf_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a clipped result sits at one end of the range
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            (m_tdata == {1'b0, {(DATA_WIDTH-1){1'b1}}})
            || (m_tdata == {1'b1, {(DATA_WIDTH-1){1'b0}}}))
        else $error("saturated flag on an in-range value");

    // an apply needs several stages, so no result follows an item at once
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after an input item");

endmodule

bind layer_norm_forward lnf_checker u_lnf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Layer normalization forward block testbench
// Streams load and apply items into the block and predicts every
// normalized element from a local fixed-point model of the statistics.
// Register settings change between samples; both stream sides idle at
// random, and one long output stall forces the input to back up.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lnf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 300;
    localparam longint unsigned BIG_MAG = 64'd1 << 50;

    typedef struct {
        logic [DATA_WIDTH-1:0] y;
        bit                    last;
        bit                    sat;
    } norm_result_t;

    class norm_scoreboard;
        longint                 elem_store [MAX_ELEMENTS_DEF];
        longint                 sum_x;
        longint unsigned        sum_sq;
        longint                 mean_q24;
        logic [INV_W-1:0]       inv_dev;
        int                     idx;
        phase_t                 ph;
        int unsigned            cnt_reg;
        int unsigned            eps_reg;
        bit                     scale_en;
        bit                     bias_en;
        norm_result_t           pending [$];
        int                     errors;

        function new();
            foreach (elem_store[i]) elem_store[i] = 0;
            sum_x = 0; sum_sq = 0; mean_q24 = 0; inv_dev = '0;
            idx = 0; ph = PH_LOADING;
            cnt_reg = 1024; eps_reg = 168; scale_en = 0; bias_en = 0;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t r, int unsigned v);
            case (r)
                REG_ELEMENT_COUNT: cnt_reg = v & 32'h7FF;
                REG_EPSILON:       eps_reg = v & 32'hFFFFFF;
                REG_USE_SCALE:     scale_en = v[0];
                REG_USE_BIAS:      bias_en = v[0];
                default: ;
            endcase
        endfunction

        function int unsigned n_active();
            if (cnt_reg == 0) return 1;
            if (cnt_reg > MAX_ELEMENTS_DEF) return MAX_ELEMENTS_DEF;
            return cnt_reg;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            for (int i = 0; i < 32; i++)
            begin
                if (v >= res + bitv)
                begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        // round half up by sh bits, cap at BIG_MAG
        function longint unsigned round_mul(longint unsigned a, longint unsigned b, int sh);
            longint unsigned half, p;
            half = 64'd1 << (sh - 1);
            if (b != 0 && a > (64'hFFFF_FFFF_FFFF_FFFF - half) / b) return BIG_MAG;
            p = (a * b + half) >> sh;
            return (p > BIG_MAG) ? BIG_MAG : p;
        endfunction

        function void form_stats(int unsigned n);
            longint unsigned smag, mq, var_q24, total, root, nsq, s2;
            smag = (sum_x < 0) ? longint'(-sum_x) : longint'(sum_x);
            mq = (smag << FRAC_BITS) / n;
            mean_q24 = (sum_x < 0) ? -longint'(mq) : longint'(mq);
            if (n == 1)
                var_q24 = 64'd1 << 24;
            else
            begin
                nsq = longint'(n) * sum_sq;
                s2 = smag * smag;
                var_q24 = (nsq > s2) ? (nsq - s2) / (longint'(n) * n) : 0;
            end
            total = var_q24 + eps_reg;
            if (total == 0)
                inv_dev = INV_MAX;
            else
            begin
                root = int_sqrt((64'd1 << 56) / total);
                inv_dev = (root > 64'hFFFF_FFFF) ? INV_MAX : root[31:0];
            end
            sum_x = 0;
            sum_sq = 0;
        endfunction

        function void note_item(kind_t k, shortint x, shortint sc, shortint bi);
            int unsigned n;
            longint d, val;
            longint unsigned dm, n24, m12, xm;
            bit neg, sat;
            norm_result_t r;
            n = n_active();
            if (k == KIND_LOAD)
            begin
                if (ph != PH_LOADING) return;
                elem_store[idx] = x;
                sum_x += x;
                xm = (x < 0) ? longint'(-longint'(x)) : longint'(x);
                sum_sq += xm * xm;
                idx++;
                if (idx >= n)
                begin
                    form_stats(n);
                    idx = 0;
                    ph = PH_APPLYING;
                end
                return;
            end
            if (ph != PH_APPLYING) return;
            d = elem_store[idx] * 4096 - mean_q24;
            dm = (d < 0) ? longint'(-d) : longint'(d);
            neg = d < 0;
            n24 = round_mul(dm, longint'(inv_dev), 16);
            if (scale_en)
            begin
                if (sc < 0) neg = !neg;
                m12 = round_mul(n24, (sc < 0) ? longint'(-longint'(sc)) : longint'(sc), 24);
            end
            else
                m12 = round_mul(n24, 1, FRAC_BITS);
            val = neg ? -longint'(m12) : longint'(m12);
            if (bias_en) val += bi;
            sat = 0;
            if (val > 32767) begin val = 32767; sat = 1; end
            if (val < -32768) begin val = -32768; sat = 1; end
            idx++;
            r.last = idx >= n;
            if (r.last)
            begin
                idx = 0;
                ph = PH_LOADING;
            end
            r.y = val[DATA_WIDTH-1:0];
            r.sat = sat;
            pending.push_back(r);
        endfunction

        function void check_result(logic [DATA_WIDTH-1:0] y, logic last, logic sat);
            norm_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result y=%h last=%b sat=%b", y, last, sat);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (y !== e.y)
            begin
                $error("normalized_value expected %h got %h", e.y, y);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("is_last expected %b got %b", e.last, last);
                errors++;
            end
            if (sat !== e.sat)
            begin
                $error("saturated expected %b got %b", e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [3*DATA_WIDTH-1:0]   s_tdata;
    logic                      s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [DATA_WIDTH-1:0]     m_tdata;
    logic                      m_tlast;
    logic                      m_tuser;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [PDATA_W-1:0]        pwdata;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    norm_scoreboard sb;
    int  tx_idle_pct;
    int  rx_stall_pct;
    bit  hold_req;
    int  quiet_cycles;
    int  item_total;

    layer_norm_forward u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // result side: check, then pick the next ready
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast, m_tuser);
            if (hold_req)
            begin
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (500) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(kind_t k, shortint x, shortint sc, shortint bi);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {bi, sc, x};
        do @(posedge clk); while (!s_tready);
        sb.note_item(k, x, sc, bi);
        item_total++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, int unsigned v);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(r) << 2;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(r, v);
    endtask

    function automatic shortint rand_elem(int style);
        case (style)
            0: return shortint'($urandom);
            1: return shortint'($urandom_range(0, 2000)) - 16'sd1000;
            default: return 16'sd1234;
        endcase
    endfunction

    // loads with some stray applies, then applies with some stray loads
    task automatic run_sample(int n, int style);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 5)
                send_item(KIND_APPLY, shortint'($urandom), shortint'($urandom),
                          shortint'($urandom));
            send_item(KIND_LOAD, rand_elem(style), shortint'($urandom), shortint'($urandom));
        end
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 5)
                send_item(KIND_LOAD, shortint'($urandom), shortint'($urandom),
                          shortint'($urandom));
            send_item(KIND_APPLY, shortint'($urandom), shortint'($urandom), shortint'($urandom));
        end
    endtask

    initial
    begin
        int sample_no;
        int n;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_req = 0;
        quiet_cycles = 0;
        item_total = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero count acts as one; full-range element with scale and bias
        write_reg(REG_ELEMENT_COUNT, 0);
        write_reg(REG_USE_SCALE, 1);
        write_reg(REG_USE_BIAS, 1);
        send_item(KIND_APPLY, 16'sd5, 16'sd5, 16'sd5);
        send_item(KIND_LOAD, 16'sd32767, 16'sd0, 16'sd0);
        send_item(KIND_APPLY, 16'sd0, -16'sd32768, -16'sd32768);
        // zero variance with zero epsilon
        write_reg(REG_ELEMENT_COUNT, 2);
        write_reg(REG_EPSILON, 0);
        send_item(KIND_LOAD, 16'sd5, 16'sd0, 16'sd0);
        send_item(KIND_LOAD, 16'sd5, 16'sd0, 16'sd0);
        send_item(KIND_APPLY, 16'sd0, 16'sd32767, 16'sd32767);
        send_item(KIND_APPLY, 16'sd0, 16'sd1, -16'sd1);
        send_item(KIND_LOAD, -16'sd32768, 16'sd0, 16'sd0);
        send_item(KIND_LOAD, 16'sd32767, 16'sd0, 16'sd0);
        send_item(KIND_APPLY, 16'sd0, 16'sd32767, 16'sd32767);
        send_item(KIND_LOAD, 16'sd1, 16'sd0, 16'sd0);
        send_item(KIND_APPLY, 16'sd0, -16'sd32768, -16'sd32768);
        // largest epsilon, no scale or bias
        write_reg(REG_ELEMENT_COUNT, 3);
        write_reg(REG_EPSILON, 24'hFFFFFF);
        write_reg(REG_USE_SCALE, 0);
        write_reg(REG_USE_BIAS, 0);
        send_item(KIND_LOAD, -16'sd32768, 16'sd0, 16'sd0);
        send_item(KIND_LOAD, 16'sd0, 16'sd0, 16'sd0);
        send_item(KIND_LOAD, 16'sd32767, 16'sd0, 16'sd0);
        send_item(KIND_APPLY, 16'sd0, 16'sd0, 16'sd0);
        send_item(KIND_APPLY, 16'sd0, 16'sd0, 16'sd0);
        send_item(KIND_APPLY, 16'sd0, 16'sd0, 16'sd0);

        item_total = 0;
        sample_no = 0;
        while (item_total < 1950)
        begin
            case (sample_no % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 69; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 69; end
                default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
            endcase
            if (sample_no == 10)
            begin
                write_reg(REG_ELEMENT_COUNT, 2047);
                n = MAX_ELEMENTS_DEF;
            end
            else if (sample_no == 3)
            begin
                write_reg(REG_ELEMENT_COUNT, 64);
                n = 64;
            end
            else if (sample_no == 0 || $urandom_range(3) == 0)
            begin
                n = ($urandom_range(4) == 0) ? $urandom_range(2, 64) : $urandom_range(1, 12);
                write_reg(REG_ELEMENT_COUNT, n);
                write_reg(REG_EPSILON, ($urandom_range(3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                               : $urandom_range(0, 400));
                write_reg(REG_USE_SCALE, $urandom_range(1));
                write_reg(REG_USE_BIAS, $urandom_range(1));
            end
            else
                n = sb.n_active();
            if (sample_no == 3)
                hold_req = 1;
            if (sample_no == 5)
                drain();
            run_sample(n, (n > 1 && $urandom_range(9) == 0) ? 2 : $urandom_range(1));
            sample_no++;
        end

        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire

[files.f]
sv/lnf_pkg.sv
sv/lnf_store.sv
sv/lnf_iter.sv
sv/layer_norm_forward.sv
sv/lnf_checker.sv
test/testbench.sv
